### rtl/mbrtu_pkg.sv
package mbrtu_pkg;

    localparam int RxCapacityDefault = 256;
    localparam logic [7:0] SlaveAddrReset = 8'hA2;
    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;

    localparam logic [2:0] KindByte   = 3'd0;
    localparam logic [2:0] KindEnd    = 3'd1;
    localparam logic [2:0] KindStatus = 3'd2;
    localparam logic [2:0] KindCurr   = 3'd3;
    localparam logic [2:0] KindBright = 3'd4;

    localparam logic [1:0] OutTx     = 2'd0;
    localparam logic [1:0] OutMode   = 2'd1;
    localparam logic [1:0] OutBright = 2'd2;

    localparam logic [7:0] FcReadHold  = 8'h03;
    localparam logic [7:0] FcReadInput = 8'h04;
    localparam logic [7:0] FcWrite     = 8'h06;
    localparam logic [7:0] ExcFlag     = 8'h80;
    localparam logic [7:0] ExcFunc     = 8'h01;
    localparam logic [7:0] ExcAddr     = 8'h02;
    localparam logic [7:0] ExcValue    = 8'h03;

    localparam logic [3:0] AddrSlave = 4'h0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC,
        S_EVENT,
        S_MSG,
        S_CRC_LO,
        S_CRC_HI
    } t_state;

    // Shift unit control: load a seed, fold a byte one bit per cycle while feed is set.
    typedef struct packed {
        logic        load;
        logic        feed;
        logic [15:0] seed;
        logic [7:0]  data;
    } t_crc_ctl;

endpackage

### rtl/mbrtu_crc.sv
module mbrtu_crc (
    input  logic                i_clk,
    input  mbrtu_pkg::t_crc_ctl i_ctl,
    output logic [15:0]         o_crc,
    output logic [15:0]         o_next,
    output logic                o_done
);
    import mbrtu_pkg::*;

    logic [15:0] r_crc, n_crc;
    logic [3:0]  r_bit, n_bit;
    logic [15:0] w_x;

    // One bit of the reflected polynomial per cycle while fed; byte xor on the first.
    always_comb begin
        w_x = (r_bit == 4'd0) ? (r_crc ^ {8'd0, i_ctl.data}) : r_crc;
        n_crc = r_crc;
        n_bit = r_bit;
        if (i_ctl.load) begin
            n_crc = i_ctl.seed;
            n_bit = 4'd0;
        end else if (i_ctl.feed) begin
            n_crc = w_x[0] ? ((w_x >> 1) ^ CrcPoly) : (w_x >> 1);
            n_bit = (r_bit == 4'd7) ? 4'd0 : r_bit + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
        r_bit <= n_bit;
    end

    assign o_crc  = r_crc;
    assign o_next = n_crc;
    assign o_done = i_ctl.feed && (r_bit == 4'd7);
endmodule

### rtl/modbus_rtu_register_slave_unit.sv
// Modbus RTU slave, CRC-16/MODBUS. Words in: received byte, frame end, or an
// application update. A received byte is accepted, then folded one bit per
// cycle into the running CRC through the shared shift unit. Updates, ignored
// kinds and frame ends that draw no reply pass through the CRC state without
// feeding it and give no result. A frame end that draws a reply builds the
// message at acceptance, seeds the CRC (held while a mode or brightness event
// word waits), then streams each reply byte: the byte is folded into the CRC,
// then its word is held until taken. The reply CRC is then latched, and the two
// CRC bytes follow, each held through any output stall.
// Longest reply (read of five input registers) is 15 bytes.
// o_stall is high while busy. A reset-time slave address of 0xA2 applies until
// written over the APB port.
module modbus_rtu_register_slave_unit #(
    parameter int RX_CAPACITY = mbrtu_pkg::RxCapacityDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_rx_byte,
    input  logic [15:0] i_value_a,
    input  logic [15:0] i_value_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_tx_byte,
    output logic [7:0]  o_app_value,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mbrtu_pkg::*;

    localparam int CW = $clog2(RX_CAPACITY + 1);

    t_state r_state, n_state;
    logic [7:0]  r_addr;
    logic [CW-1:0] r_cnt;
    logic [7:0]  r_hdr [6];
    logic [2:0]  r_mode;
    logic [7:0]  r_bright;
    logic [15:0] r_status, r_cur0, r_cur1;
    logic [7:0]  r_msg [13];
    logic [3:0]  r_len, r_idx;
    logic        r_event, r_evkind;
    logic [7:0]  r_evval;
    logic [15:0] r_rxcrc;
    logic        r_feedrx;
    logic [7:0]  r_bytein;
    logic [15:0] r_txcrc;
    logic        r_sent;

    t_crc_ctl   w_ctl;
    logic [15:0] w_crc;
    logic [15:0] w_next;
    logic        w_done;
    logic        w_acc, w_out_acc;

    mbrtu_crc u_crc (
        .i_clk(i_clk), .i_ctl(w_ctl), .o_crc(w_crc), .o_next(w_next), .o_done(w_done)
    );

    assign pready = 1'b1;
    assign prdata = (paddr == AddrSlave[1:0]) ? {24'd0, r_addr} : 32'd0;
    assign o_stall = (r_state != S_IDLE);
    assign w_acc = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;

    function automatic logic [15:0] rd_reg(input logic hold, input logic [2:0] i,
                                           input logic [2:0] m, input logic [7:0] b,
                                           input logic [15:0] s, input logic [15:0] c0,
                                           input logic [15:0] c1);
        logic [15:0] v;
        v = 16'd0;
        if (hold) v = (i == 3'd0) ? {13'd0, m} : {8'd0, b};
        else case (i)
            3'd0: v = s;
            3'd1: v = c0;
            3'd2: v = c1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // Frame-end decode, all from registered header state.
    logic [15:0] w_a, w_b;
    logic [16:0] w_end;
    logic        w_ok, w_rd, w_wr;
    logic        w_rd_ok, w_wr_ok, w_mode_ok, w_bright_ok;
    logic [7:0]  w_fc;
    logic [7:0]  w_exc;
    logic [3:0]  w_len;
    logic [15:0] w_rdv;
    logic [7:0]  w_msg [13];
    always_comb begin
        w_fc  = r_hdr[1];
        w_a   = {r_hdr[2], r_hdr[3]};
        w_b   = {r_hdr[4], r_hdr[5]};
        w_end = {1'b0, w_a} + {1'b0, w_b};
        w_ok  = (r_cnt >= CW'(4)) && (r_hdr[0] == r_addr) && (r_rxcrc == 16'd0);
        w_rd  = (w_fc == FcReadHold || w_fc == FcReadInput) && r_cnt >= CW'(8);
        w_wr  = (w_fc == FcWrite) && r_cnt >= CW'(8);
        w_rd_ok = w_rd && (w_b != 16'd0) &&
                  (w_end <= ((w_fc == FcReadHold) ? 17'd2 : 17'd5));
        w_mode_ok = (w_a == 16'd0) && (w_b inside {16'd0, 16'd2, 16'd4, 16'd5});
        w_bright_ok = (w_a == 16'd1) && (w_b <= 16'd255);
        w_wr_ok = w_wr && (w_mode_ok || w_bright_ok);
        if (w_rd) w_exc = ExcAddr;
        else if (w_wr) w_exc = (w_a == 16'd0 || w_a == 16'd1) ? ExcValue : ExcAddr;
        else w_exc = ExcFunc;
        w_len = 4'd3;
        if (w_rd_ok) w_len = 4'd3 + {w_b[2:0], 1'b0};
        else if (w_wr_ok) w_len = 4'd6;
        // Build the whole reply: address, function, count or code, then data.
        w_msg[0] = r_addr;
        w_msg[1] = (w_rd_ok || w_wr_ok) ? w_fc : (w_fc | ExcFlag);
        w_msg[2] = w_exc;
        if (w_rd_ok) w_msg[2] = {w_b[6:0], 1'b0};
        else if (w_wr_ok) w_msg[2] = r_hdr[2];
        w_rdv = 16'd0;
        for (int i = 0; i < 5; i++) begin
            w_rdv = rd_reg(w_fc == FcReadHold, w_a[2:0] + 3'(i),
                           r_mode, r_bright, r_status, r_cur0, r_cur1);
            w_msg[3+2*i] = w_rdv[15:8];
            w_msg[4+2*i] = w_rdv[7:0];
        end
        if (w_wr_ok) begin
            w_msg[3] = r_hdr[3];
            w_msg[4] = r_hdr[4];
            w_msg[5] = r_hdr[5];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_acc) begin
                if (i_kind == KindEnd) n_state = (w_ok) ? S_EVENT : S_CRC;
                else n_state = S_CRC;
            end
            S_CRC:    if (w_done || !r_feedrx) n_state = S_IDLE;
            S_EVENT:  if (!r_event || w_out_acc) n_state = S_MSG;
            S_MSG:    if (r_idx == r_len) n_state = S_CRC_LO;
            S_CRC_LO: if (w_out_acc) n_state = S_CRC_HI;
            S_CRC_HI: if (w_out_acc) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Shift unit control and output word.
    always_comb begin
        w_ctl = '{load: 1'b0, feed: 1'b0, seed: 16'd0, data: 8'd0};
        o_valid = 1'b0;
        o_out_kind = OutTx;
        o_tx_byte = 8'd0;
        o_app_value = 8'd0;
        o_last = 1'b0;
        case (r_state)
            S_IDLE: begin
                // Seed the unit with the running CRC, ready for the next byte.
                w_ctl.load = 1'b1;
                w_ctl.seed = r_rxcrc;
            end
            S_CRC: begin
                w_ctl.feed = r_feedrx;
                w_ctl.data = r_bytein;
            end
            S_EVENT: begin
                w_ctl.load = 1'b1;
                w_ctl.seed = CrcInit;
                o_valid = r_event;
                o_out_kind = r_evkind ? OutBright : OutMode;
                o_app_value = r_evval;
            end
            S_MSG: if (r_idx != r_len) begin
                w_ctl.feed = !r_sent;
                w_ctl.data = r_msg[r_idx];
                o_valid = r_sent;
                o_tx_byte = r_msg[r_idx];
            end
            S_CRC_LO: begin
                o_valid = 1'b1;
                o_tx_byte = r_txcrc[7:0];
            end
            S_CRC_HI: begin
                o_valid = 1'b1;
                o_tx_byte = r_txcrc[15:8];
                o_last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr <= SlaveAddrReset;
            r_cnt <= '0;
            r_rxcrc <= CrcInit;
            r_mode <= '0;
            r_bright <= '0;
            r_status <= '0;
            r_cur0 <= '0;
            r_cur1 <= '0;
            r_feedrx <= 1'b0;
            r_event <= 1'b0;
            r_sent <= 1'b0;
            r_idx <= '0;
            r_len <= '0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && paddr == AddrSlave[1:0])
                r_addr <= pwdata[7:0];
            if (r_state == S_IDLE && w_acc) begin
                r_feedrx <= (i_kind == KindByte) && (r_cnt < CW'(RX_CAPACITY));
                case (i_kind)
                    KindByte: if (r_cnt < CW'(RX_CAPACITY)) begin
                        if (r_cnt < CW'(6)) r_hdr[r_cnt[2:0]] <= i_rx_byte;
                        r_cnt <= r_cnt + CW'(1);
                        r_bytein <= i_rx_byte;
                    end
                    KindEnd: begin
                        r_cnt <= '0;
                        r_rxcrc <= CrcInit;
                        r_idx <= '0;
                        r_sent <= 1'b0;
                        r_msg <= w_msg;
                        r_len <= w_len;
                        // Apply an accepted write only for a frame addressed to us.
                        r_event <= w_ok && w_wr_ok;
                        r_evkind <= w_bright_ok;
                        r_evval <= w_b[7:0];
                        if (w_ok && w_wr_ok && w_mode_ok) begin
                            r_mode <= w_b[2:0];
                            r_status <= w_b;
                        end
                        if (w_ok && w_wr_ok && w_bright_ok) r_bright <= w_b[7:0];
                    end
                    KindStatus: r_status <= i_value_a;
                    KindCurr: begin
                        r_cur0 <= i_value_a;
                        r_cur1 <= i_value_b;
                    end
                    KindBright: r_bright <= (i_value_a > 16'd255) ? 8'hFF : i_value_a[7:0];
                    default: ;
                endcase
            end
            if (r_state == S_CRC && w_done) r_rxcrc <= w_next;
            if (r_state == S_MSG && r_idx != r_len) begin
                if (w_out_acc) begin
                    r_sent <= 1'b0;
                    r_idx <= r_idx + 4'd1;
                end else if (!r_sent && w_done) begin
                    r_sent <= 1'b1;
                end
            end
            if (r_state == S_MSG && r_idx == r_len) r_txcrc <= w_crc;
        end
    end

`ifndef SYNTHESIS
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last) |=> (r_state == S_IDLE)) else $error("last");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("busy");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_valid) else $error("quiet");
`endif
endmodule

### tb/tb_modbus_rtu_register_slave_unit.sv
module tb_modbus_rtu_register_slave_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import mbrtu_pkg::*;

    // One input word: kind plus the three payload fields.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  rx_byte;
        logic [15:0] value_a;
        logic [15:0] value_b;
    } t_word;

    // One reply word or application event.
    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] tx_byte;
        logic [7:0] app_value;
        logic       last;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_kind;
    logic [7:0]  i_rx_byte;
    logic [15:0] i_value_a;
    logic [15:0] i_value_b;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_out_kind;
    logic [7:0]  o_tx_byte;
    logic [7:0]  o_app_value;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    modbus_rtu_register_slave_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_rx_byte(i_rx_byte),
        .i_value_a(i_value_a), .i_value_b(i_value_b),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_kind(o_out_kind), .o_tx_byte(o_tx_byte),
        .o_app_value(o_app_value), .o_last(o_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state: our own copy of the slave's registers and frame buffer.
    logic [7:0]  own_addr;
    int          byte_cnt;
    logic [7:0]  hdr [6];
    logic [15:0] crc_acc;
    logic [2:0]  mode_reg;
    logic [7:0]  bright_reg;
    logic [15:0] status_reg;
    logic [15:0] curr_reg [2];

    t_word  pending_words[$];
    t_reply expected_replies[$];

    int  errors;
    int  sent_words;
    int  got_replies;
    int  frames_sent;
    int  idle_pct;
    int  stall_pct;
    int  hold_cycles;
    bit  hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        c = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

    function automatic void push_reply(logic [1:0] k, logic [7:0] tx, logic [7:0] app);
        t_reply r;
        r.out_kind = k;
        r.tx_byte = tx;
        r.app_value = app;
        r.last = 1'b0;
        expected_replies.push_back(r);
    endfunction

    // Queue a reply message and its trailing CRC, low byte first.
    function automatic void push_msg(logic [7:0] msg [], int len);
        logic [15:0] c;
        c = 16'hFFFF;
        for (int i = 0; i < len; i++) begin
            c = crc_step(c, msg[i]);
            push_reply(OutTx, msg[i], 8'h00);
        end
        push_reply(OutTx, c[7:0], 8'h00);
        push_reply(OutTx, c[15:8], 8'h00);
    endfunction

    function automatic void push_exception(logic [7:0] fc, logic [7:0] code);
        logic [7:0] m [];
        m = new[3];
        m[0] = own_addr;
        m[1] = fc | ExcFlag;
        m[2] = code;
        push_msg(m, 3);
    endfunction

    function automatic logic [15:0] input_reg(int idx);
        case (idx)
            0: return status_reg;
            1: return curr_reg[0];
            2: return curr_reg[1];
            default: return 16'h0000;
        endcase
    endfunction

    // Work out what the slave answers when the line goes idle.
    function automatic void predict_frame_end();
        logic [7:0] fc;
        logic [7:0] m [];
        int start_reg, qty, limit, wreg, wval, len, before_n;
        logic [15:0] v;
        logic [7:0] exc;
        before_n = expected_replies.size();
        if (byte_cnt < 4 || hdr[0] != own_addr || crc_acc != 16'h0000)
            return;
        fc = hdr[1];
        if ((fc == FcReadHold || fc == FcReadInput) && byte_cnt >= 8) begin
            start_reg = {hdr[2], hdr[3]};
            qty = {hdr[4], hdr[5]};
            limit = (fc == FcReadHold) ? 2 : 5;
            if (qty >= 1 && start_reg + qty <= limit) begin
                m = new[3 + 2 * qty];
                m[0] = own_addr;
                m[1] = fc;
                m[2] = 8'(qty * 2);
                len = 3;
                for (int i = 0; i < qty; i++) begin
                    if (fc == FcReadHold)
                        v = (start_reg + i == 0) ? {13'd0, mode_reg} : {8'd0, bright_reg};
                    else
                        v = input_reg(start_reg + i);
                    m[len++] = v[15:8];
                    m[len++] = v[7:0];
                end
                push_msg(m, len);
            end else begin
                push_exception(fc, ExcAddr);
            end
        end else if (fc == FcWrite && byte_cnt >= 8) begin
            wreg = {hdr[2], hdr[3]};
            wval = {hdr[4], hdr[5]};
            exc = 8'h00;
            if (wreg == 0) begin
                if (wval == 0 || wval == 2 || wval == 4 || wval == 5) begin
                    mode_reg = 3'(wval);
                    status_reg = 16'(wval);
                    push_reply(OutMode, 8'h00, 8'(wval));
                end else begin
                    exc = ExcValue;
                end
            end else if (wreg == 1) begin
                if (wval <= 255) begin
                    bright_reg = 8'(wval);
                    push_reply(OutBright, 8'h00, 8'(wval));
                end else begin
                    exc = ExcValue;
                end
            end else begin
                exc = ExcAddr;
            end
            if (exc == 8'h00) begin
                m = new[6];
                m[0] = own_addr;
                m[1] = FcWrite;
                for (int i = 2; i < 6; i++) m[i] = hdr[i];
                push_msg(m, 6);
            end else begin
                push_exception(FcWrite, exc);
            end
        end else begin
            push_exception(fc, ExcFunc);
        end
        if (expected_replies.size() > before_n)
            expected_replies[$].last = 1'b1;
    endfunction

    function automatic void predict_word(t_word w);
        case (w.kind)
            KindByte: begin
                if (byte_cnt < RxCapacityDefault) begin
                    if (byte_cnt < 6) hdr[byte_cnt] = w.rx_byte;
                    crc_acc = crc_step(crc_acc, w.rx_byte);
                    byte_cnt++;
                end
            end
            KindEnd: begin
                predict_frame_end();
                byte_cnt = 0;
                crc_acc = 16'hFFFF;
            end
            KindStatus: status_reg = w.value_a;
            KindCurr: begin
                curr_reg[0] = w.value_a;
                curr_reg[1] = w.value_b;
            end
            KindBright: bright_reg = (w.value_a > 255) ? 8'hFF : w.value_a[7:0];
            default: ;
        endcase
    endfunction

    // Sender: hold the payload while stalled, advance on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_word({i_kind, i_rx_byte, i_value_a, i_value_b});
                sent_words++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    t_word w;
                    w = pending_words.pop_front();
                    i_valid <= 1'b1;
                    {i_kind, i_rx_byte, i_value_a, i_value_b} <= w;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down on its own.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cycles <= 0;
        end else if (hold_req && hold_cycles == 0) begin
            hold_cycles <= 400;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Receiver: random stalls, plus the long hold-off while it runs.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                t_reply want;
                got_replies++;
                if (expected_replies.size() == 0) begin
                    $error("unexpected reply word kind=%0d tx=%02h", o_out_kind, o_tx_byte);
                    errors++;
                end else begin
                    want = expected_replies.pop_front();
                    if (o_out_kind !== want.out_kind) begin
                        $error("out_kind expected %0d got %0d", want.out_kind, o_out_kind);
                        errors++;
                    end
                    if (o_tx_byte !== want.tx_byte) begin
                        $error("tx_byte expected %02h got %02h", want.tx_byte, o_tx_byte);
                        errors++;
                    end
                    if (o_app_value !== want.app_value) begin
                        $error("app_value expected %02h got %02h", want.app_value, o_app_value);
                        errors++;
                    end
                    if (o_last !== want.last) begin
                        $error("last expected %0d got %0d", want.last, o_last);
                        errors++;
                    end
                end
            end
            i_stall <= (hold_cycles != 0) || ($urandom_range(99) < stall_pct);
        end
    end

    task automatic apb_write(logic [1:0] a, logic [31:0] d);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Settle: wait for every expected word, then the worst-case busy time.
    task automatic drain_all();
        while (pending_words.size() > 0 || i_valid || expected_replies.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_address(logic [7:0] a);
        drain_all();
        apb_write(AddrSlave[1:0], {24'd0, a});
        own_addr = a;
    endtask

    function automatic void add_word(logic [2:0] k, logic [7:0] b, logic [15:0] va,
                                     logic [15:0] vb);
        t_word w;
        w.kind = k; w.rx_byte = b; w.value_a = va; w.value_b = vb;
        pending_words.push_back(w);
    endfunction

    // Queue a frame; optionally corrupt the CRC, then mark the line idle.
    function automatic void add_frame(logic [7:0] body [], int len, bit bad_crc);
        logic [15:0] c;
        c = 16'hFFFF;
        for (int i = 0; i < len; i++) begin
            c = crc_step(c, body[i]);
            add_word(KindByte, body[i], 16'($urandom), 16'($urandom));
        end
        if (bad_crc) c = c ^ 16'(1 << $urandom_range(15));
        add_word(KindByte, c[7:0], 16'($urandom), 16'($urandom));
        add_word(KindByte, c[15:8], 16'($urandom), 16'($urandom));
        add_word(KindEnd, 8'($urandom), 16'($urandom), 16'($urandom));
        frames_sent++;
    endfunction

    function automatic void add_request(logic [7:0] a, logic [7:0] fc, logic [15:0] p1,
                                        logic [15:0] p2, bit bad_crc);
        logic [7:0] m [];
        m = new[6];
        m[0] = a; m[1] = fc; m[2] = p1[15:8]; m[3] = p1[7:0]; m[4] = p2[15:8];
        m[5] = p2[7:0];
        add_frame(m, 6, bad_crc);
    endfunction

    // Random mix: mostly well-formed requests to us, some noise.
    function automatic void add_random(int n);
        logic [7:0] m [];
        int len, pick, fcsel;
        logic [7:0] fc;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                fcsel = $urandom_range(9);
                fc = (fcsel < 4) ? FcReadHold : (fcsel < 7) ? FcReadInput :
                     (fcsel < 9) ? FcWrite : 8'($urandom);
                if (fc == FcWrite)
                    add_request(own_addr, fc, 16'($urandom_range(2)),
                                ($urandom_range(3) == 0) ? 16'($urandom) :
                                16'($urandom_range(6)), $urandom_range(19) == 0);
                else if ($urandom_range(7) == 0)
                    add_request(own_addr, fc, 16'($urandom), 16'($urandom), 1'b0);
                else
                    add_request(own_addr, fc, 16'($urandom_range(5)),
                                16'($urandom_range(5)), $urandom_range(19) == 0);
            end else if (pick < 68) begin
                add_request(8'($urandom), FcReadHold, 16'd0, 16'd2, 1'b0);
            end else if (pick < 74) begin
                len = $urandom_range(2, 5);
                m = new[len];
                m[0] = own_addr;
                m[1] = ($urandom_range(1)) ? FcReadInput : FcWrite;
                for (int j = 2; j < len; j++) m[j] = 8'($urandom);
                add_frame(m, len, 1'b0);
            end else if (pick < 90) begin
                add_word(3'($urandom_range(2, 7)), 8'($urandom), 16'($urandom),
                         16'($urandom));
            end else begin
                len = $urandom_range(0, 9);
                for (int j = 0; j < len; j++)
                    add_word(KindByte, 8'($urandom), 16'($urandom), 16'($urandom));
                add_word(KindEnd, 8'($urandom), 16'($urandom), 16'($urandom));
            end
        end
    endfunction

    initial begin
        logic [7:0] m [];
        i_rst_n = 1'b0;
        i_valid = 1'b0; i_kind = '0; i_rx_byte = '0; i_value_a = '0; i_value_b = '0;
        i_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        errors = 0; sent_words = 0; got_replies = 0; frames_sent = 0;
        idle_pct = 0; stall_pct = 0; hold_req = 1'b0;
        own_addr = SlaveAddrReset;
        byte_cnt = 0; crc_acc = 16'hFFFF;
        mode_reg = '0; bright_reg = '0; status_reg = '0;
        curr_reg[0] = '0; curr_reg[1] = '0;
        foreach (hdr[i]) hdr[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset address, every function and each exception path.
        add_word(KindStatus, 8'hFF, 16'hFFFF, 16'h0000);
        add_word(KindCurr, 8'h00, 16'h0000, 16'hFFFF);
        add_word(KindBright, 8'h00, 16'hFFFF, 16'hFFFF);
        add_word(3'd7, 8'hFF, 16'hFFFF, 16'hFFFF);
        add_request(own_addr, FcReadInput, 16'd0, 16'd5, 1'b0);
        add_request(own_addr, FcReadHold, 16'd0, 16'd2, 1'b0);
        add_request(own_addr, FcReadHold, 16'd1, 16'd2, 1'b0);
        add_request(own_addr, FcReadInput, 16'd0, 16'd0, 1'b0);
        add_request(own_addr, FcWrite, 16'd0, 16'd5, 1'b0);
        add_request(own_addr, FcWrite, 16'd0, 16'd3, 1'b0);
        add_request(own_addr, FcWrite, 16'd1, 16'd255, 1'b0);
        add_request(own_addr, FcWrite, 16'd1, 16'd256, 1'b0);
        add_request(own_addr, FcWrite, 16'hFFFF, 16'd0, 1'b0);
        add_request(own_addr, 8'h2B, 16'd0, 16'd1, 1'b0);
        add_request(own_addr, FcReadHold, 16'd0, 16'd1, 1'b1);
        add_request(8'h00, FcReadHold, 16'd0, 16'd1, 1'b0);
        m = new[2];
        m[0] = own_addr; m[1] = FcReadHold;
        add_frame(m, 2, 1'b0);
        m[1] = 8'hFF;
        add_frame(m, 2, 1'b0);
        add_frame(m, 0, 1'b1);
        // Overflow: a full-capacity frame whose CRC bytes fall past the end.
        m = new[256];
        m[0] = own_addr; m[1] = FcReadHold;
        for (int i = 2; i < 256; i++) m[i] = 8'($urandom);
        add_frame(m, 256, 1'b0);
        add_word(KindEnd, 8'h00, 16'h0000, 16'h0000);

        set_address(8'h00);
        add_random(2);
        set_address(8'hFF);
        idle_pct = 57;
        add_random(2);
        set_address(8'($urandom_range(1, 254)));
        stall_pct = 57; idle_pct = 0;
        add_random(2);
        // Long receiver hold-off while the sender keeps pushing.
        add_request(own_addr, FcReadInput, 16'd0, 16'd5, 1'b0);
        add_random(1);
        hold_req = 1'b1;
        wait (hold_cycles != 0);
        hold_req = 1'b0;
        set_address(SlaveAddrReset);
        stall_pct = 24; idle_pct = 24;
        add_random(2);
        set_address(8'($urandom));
        stall_pct = 0; idle_pct = 0;
        add_random(2);
        drain_all();

        $display("Sent %0d words in %0d frames, checked %0d reply words.",
                 sent_words, frames_sent, got_replies);
        $display("Covered five address settings, all functions, exceptions and stalls.");
        if (errors == 0 && expected_replies.size() == 0) begin
            $display("Verification passed");
        end else begin
            if (expected_replies.size() > 0)
                $error("%0d reply words never arrived", expected_replies.size());
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
